[hw/rtl/h2r_pkg.sv]
// h2r_pkg: shared constants and types for the HSV to RGB converter.
// Field widths, hue circle geometry, parameter defaults and sector codes.
// No dependencies.
package h2r_pkg;

    localparam int HUE_W        = 16;
    localparam int IN_COLOR_W   = 12;
    localparam int OUT_COLOR_W  = 12;

    localparam int COLOR_BITS_DEFAULT        = 12;
    localparam int HUE_FRACTION_BITS_DEFAULT = 4;

    localparam int SECTOR_DEGREES = 60;
    localparam int TURN_DEGREES   = 360;
    localparam int SECTORS        = 6;

    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW,
        SECTOR_YELLOW_GREEN,
        SECTOR_GREEN_CYAN,
        SECTOR_CYAN_BLUE,
        SECTOR_BLUE_MAGENTA,
        SECTOR_MAGENTA_RED
    } sector_t;

endpackage

[hw/rtl/hsv_to_rgb_converter_core.sv]
// hsv_to_rgb_converter_core: six-stage pipelined HSV to RGB colour conversion.
// Six register stages lie between the input transaction and the result.
// Throughput: one transaction per cycle unless stalled; each stage stalls only when
// the stage after it is full and held, so back-pressure loses and repeats nothing.
// Reset: asynchronous, clears the stage valid bits only; data registers are not reset.
// Depends on h2r_pkg.
module hsv_to_rgb_converter_core
    import h2r_pkg::*;
#(
    parameter int COLOR_BITS        = COLOR_BITS_DEFAULT,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [HUE_W-1:0]       hue,
    input  logic [IN_COLOR_W-1:0]  saturation,
    input  logic [IN_COLOR_W-1:0]  brightness,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_COLOR_W-1:0] red,
    output logic [OUT_COLOR_W-1:0] green,
    output logic [OUT_COLOR_W-1:0] blue
);

    localparam int CB        = COLOR_BITS;
    localparam int STAGES    = 6;
    localparam int SECTOR    = SECTOR_DEGREES << HUE_FRACTION_BITS;
    localparam int FULL_TURN = TURN_DEGREES << HUE_FRACTION_BITS;
    localparam int HW        = ($clog2(FULL_TURN) + 1 > HUE_W) ? $clog2(FULL_TURN) + 1 : HUE_W;
    localparam int CW        = (CB > IN_COLOR_W) ? CB : IN_COLOR_W;
    localparam int FW        = $clog2(SECTOR);
    localparam int XW        = CB + FW;
    localparam int YW        = XW - HUE_FRACTION_BITS;
    localparam int RW        = $clog2(2 * SECTOR_DEGREES) + 1;
    localparam int PW        = 2 * CB;

    localparam logic [CB-1:0] CMAX     = {CB{1'b1}};
    localparam logic [XW-1:0] LOW_MASK = XW'((64'(1) << HUE_FRACTION_BITS) - 64'(1));
    localparam logic [YW-1:0] RECIP    = YW'((64'(1) << YW) / SECTOR_DEGREES);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;

    // stage 1: clamp, hue wrap, sector split
    logic [CW-1:0] sat_ext;
    logic [CW-1:0] bri_ext;
    logic [CB-1:0] s_clamp;
    logic [CB-1:0] v_clamp;
    logic [HW-1:0] h_wrap;
    logic [HW-1:0] h_base;
    sector_t       sec_next;
    logic [FW-1:0] frac_next;

    logic [CB-1:0] s1_s_reg;
    logic [CB-1:0] s1_v_reg;
    logic          s1_grey_reg;
    sector_t       s1_sec_reg;
    logic [FW-1:0] s1_frac_reg;

    // stage 2: s * frac
    logic [XW-1:0] s2_x_reg;
    logic [CB-1:0] s2_s_reg;
    logic [CB-1:0] s2_v_reg;
    logic          s2_grey_reg;
    sector_t       s2_sec_reg;

    // stage 3: reciprocal multiply by 1/60
    logic [YW-1:0]   y_val;
    logic [2*YW-1:0] recip_prod;
    logic [CB-1:0]   s3_q0_reg;
    logic [YW-1:0]   s3_y_reg;
    logic            s3_lownz_reg;
    logic [CB-1:0]   s3_s_reg;
    logic [CB-1:0]   s3_v_reg;
    logic            s3_grey_reg;
    sector_t         s3_sec_reg;

    // stage 4: quotient correction
    logic [YW-1:0] rem_full;
    logic [RW-1:0] rem;
    logic          rem_high;
    logic [CB-1:0] s4_q_reg;
    logic          s4_nz_reg;
    logic [CB-1:0] s4_s_reg;
    logic [CB-1:0] s4_v_reg;
    logic          s4_grey_reg;
    sector_t       s4_sec_reg;

    // stage 5: scale factors and products
    logic [CB-1:0] t_sub;
    logic [CB-1:0] fac_p;
    logic [CB-1:0] fac_q;
    logic [CB-1:0] fac_t;
    logic [PW-1:0] s5_pp_reg;
    logic [PW-1:0] s5_pq_reg;
    logic [PW-1:0] s5_pt_reg;
    logic [CB-1:0] s5_v_reg;
    logic          s5_grey_reg;
    sector_t       s5_sec_reg;

    // stage 6: divide by CMAX, channel select
    logic [CB-1:0] p_val;
    logic [CB-1:0] q_val;
    logic [CB-1:0] t_val;
    logic [CB-1:0] r_sel;
    logic [CB-1:0] g_sel;
    logic [CB-1:0] b_sel;
    logic [OUT_COLOR_W-1:0] s6_r_reg;
    logic [OUT_COLOR_W-1:0] s6_g_reg;
    logic [OUT_COLOR_W-1:0] s6_b_reg;

    // floor(x / CMAX) for x <= CMAX^2
    function automatic logic [CB-1:0] div_cmax(input logic [PW-1:0] x);
        logic [CB-1:0] hi;
        logic [CB:0]   r;
        hi = x[PW-1:CB];
        r  = {1'b0, hi} + {1'b0, x[CB-1:0]};
        div_cmax = hi + CB'(r >= {1'b0, CMAX});
    endfunction

    function automatic logic [OUT_COLOR_W-1:0] to_out(input logic [CB-1:0] c);
        logic [CW-1:0] e;
        e = CW'(c);
        to_out = e[OUT_COLOR_W-1:0];
    endfunction

    // handshake: a stage takes new data when empty or when its successor moves
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];
    assign red       = s6_r_reg;
    assign green     = s6_g_reg;
    assign blue      = s6_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        sat_ext = CW'(saturation);
        bri_ext = CW'(brightness);
        s_clamp = (sat_ext > CW'(CMAX)) ? CMAX : sat_ext[CB-1:0];
        v_clamp = (bri_ext > CW'(CMAX)) ? CMAX : bri_ext[CB-1:0];
        h_wrap  = HW'(hue);
        if (h_wrap >= HW'(FULL_TURN))
        begin
            h_wrap = '0;
        end
        sec_next = SECTOR_RED_YELLOW;
        h_base   = '0;
        for (int k = 1; k < SECTORS; k++)
        begin
            if (h_wrap >= HW'(k * SECTOR))
            begin
                sec_next = sector_t'(3'(k));
                h_base   = HW'(k * SECTOR);
            end
        end
        frac_next = FW'(h_wrap - h_base);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_s_reg    <= s_clamp;
            s1_v_reg    <= v_clamp;
            s1_grey_reg <= (s_clamp == '0);
            s1_sec_reg  <= sec_next;
            s1_frac_reg <= frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_x_reg    <= XW'(s1_s_reg) * XW'(s1_frac_reg);
            s2_s_reg    <= s1_s_reg;
            s2_v_reg    <= s1_v_reg;
            s2_grey_reg <= s1_grey_reg;
            s2_sec_reg  <= s1_sec_reg;
        end
    end

    // q0 is the true quotient or one below it
    assign y_val      = YW'(s2_x_reg >> HUE_FRACTION_BITS);
    assign recip_prod = (2*YW)'(y_val) * (2*YW)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_q0_reg    <= CB'(recip_prod[2*YW-1:YW]);
            s3_y_reg     <= y_val;
            s3_lownz_reg <= |(s2_x_reg & LOW_MASK);
            s3_s_reg     <= s2_s_reg;
            s3_v_reg     <= s2_v_reg;
            s3_grey_reg  <= s2_grey_reg;
            s3_sec_reg   <= s2_sec_reg;
        end
    end

    assign rem_full = s3_y_reg - YW'(s3_q0_reg) * YW'(SECTOR_DEGREES);
    assign rem      = rem_full[RW-1:0];
    assign rem_high = (rem >= RW'(SECTOR_DEGREES));

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_q_reg    <= s3_q0_reg + CB'(rem_high);
            s4_nz_reg   <= s3_lownz_reg || ((rem != '0) && (rem != RW'(SECTOR_DEGREES)));
            s4_s_reg    <= s3_s_reg;
            s4_v_reg    <= s3_v_reg;
            s4_grey_reg <= s3_grey_reg;
            s4_sec_reg  <= s3_sec_reg;
        end
    end

    // s*(SECTOR-frac)/SECTOR floored = s - ceil(s*frac/SECTOR)
    assign t_sub = s4_s_reg - s4_q_reg - CB'(s4_nz_reg);
    assign fac_p = CMAX - s4_s_reg;
    assign fac_q = CMAX - s4_q_reg;
    assign fac_t = CMAX - t_sub;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_pp_reg   <= PW'(s4_v_reg) * PW'(fac_p);
            s5_pq_reg   <= PW'(s4_v_reg) * PW'(fac_q);
            s5_pt_reg   <= PW'(s4_v_reg) * PW'(fac_t);
            s5_v_reg    <= s4_v_reg;
            s5_grey_reg <= s4_grey_reg;
            s5_sec_reg  <= s4_sec_reg;
        end
    end

    always_comb
    begin
        p_val = div_cmax(s5_pp_reg);
        q_val = div_cmax(s5_pq_reg);
        t_val = div_cmax(s5_pt_reg);
        case (s5_sec_reg)
            SECTOR_RED_YELLOW:   begin r_sel = s5_v_reg; g_sel = t_val;    b_sel = p_val;    end
            SECTOR_YELLOW_GREEN: begin r_sel = q_val;    g_sel = s5_v_reg; b_sel = p_val;    end
            SECTOR_GREEN_CYAN:   begin r_sel = p_val;    g_sel = s5_v_reg; b_sel = t_val;    end
            SECTOR_CYAN_BLUE:    begin r_sel = p_val;    g_sel = q_val;    b_sel = s5_v_reg; end
            SECTOR_BLUE_MAGENTA: begin r_sel = t_val;    g_sel = p_val;    b_sel = s5_v_reg; end
            default:             begin r_sel = s5_v_reg; g_sel = p_val;    b_sel = q_val;    end
        endcase
        if (s5_grey_reg)
        begin
            r_sel = s5_v_reg;
            g_sel = s5_v_reg;
            b_sel = s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_r_reg <= to_out(r_sel);
            s6_g_reg <= to_out(g_sel);
            s6_b_reg <= to_out(b_sel);
        end
    end

endmodule

[tb/tb.sv]
// tb: self-checking bench for hsv_to_rgb_converter_core, with a fixed-point colour predictor,
// directed and random HSV stimulus, bursty input and a stalling output.
// Depends on h2r_pkg and hsv_to_rgb_converter_core.
module tb
    import h2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CMAX      = (1 << COLOR_BITS_DEFAULT) - 1;
    localparam int unsigned SECTOR    = SECTOR_DEGREES << HUE_FRACTION_BITS_DEFAULT;
    localparam int unsigned FULL_TURN = TURN_DEGREES << HUE_FRACTION_BITS_DEFAULT;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [OUT_COLOR_W-1:0] red;
        logic [OUT_COLOR_W-1:0] green;
        logic [OUT_COLOR_W-1:0] blue;
    } rgb_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [HUE_W-1:0]       hue;
    logic [IN_COLOR_W-1:0]  saturation;
    logic [IN_COLOR_W-1:0]  brightness;
    logic                   out_valid;
    logic                   out_ready;
    logic [OUT_COLOR_W-1:0] red;
    logic [OUT_COLOR_W-1:0] green;
    logic [OUT_COLOR_W-1:0] blue;

    rgb_t rgb_queue[$];
    int   errors       = 0;
    int   burst_left   = 0;
    bit   gaps_on      = 1'b1;
    bit   hold_request = 1'b0;

    hsv_to_rgb_converter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned scale_colour(longint unsigned v, longint unsigned f);
        return (v * f) / CMAX;
    endfunction

    function automatic rgb_t convert_hsv(logic [HUE_W-1:0] h_in, logic [IN_COLOR_W-1:0] s_in,
                                         logic [IN_COLOR_W-1:0] v_in);
        longint unsigned h, s, v, p, q, t, frac, r, g, b;
        sector_t         sector;
        rgb_t            res;
        h = 64'(h_in);
        s = 64'(s_in);
        v = 64'(v_in);
        if (s > CMAX)
            s = CMAX;
        if (v > CMAX)
            v = CMAX;
        if (s == 0)
        begin
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            if (h >= FULL_TURN)
                h = 0;
            sector = sector_t'(h / SECTOR);
            frac   = h % SECTOR;
            p = scale_colour(v, CMAX - s);
            q = scale_colour(v, CMAX - (s * frac) / SECTOR);
            t = scale_colour(v, CMAX - (s * (SECTOR - frac)) / SECTOR);
            case (sector)
                SECTOR_RED_YELLOW:   begin r = v; g = t; b = p; end
                SECTOR_YELLOW_GREEN: begin r = q; g = v; b = p; end
                SECTOR_GREEN_CYAN:   begin r = p; g = v; b = t; end
                SECTOR_CYAN_BLUE:    begin r = p; g = q; b = v; end
                SECTOR_BLUE_MAGENTA: begin r = t; g = p; b = v; end
                default:             begin r = v; g = p; b = q; end
            endcase
        end
        res.red   = r[OUT_COLOR_W-1:0];
        res.green = g[OUT_COLOR_W-1:0];
        res.blue  = b[OUT_COLOR_W-1:0];
        return res;
    endfunction

    // one input transaction; valid stays high across back-to-back items within a burst
    task automatic send_hsv(logic [HUE_W-1:0] h, logic [IN_COLOR_W-1:0] s,
                            logic [IN_COLOR_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        hue        = h;
        saturation = s;
        brightness = v;
        do
            @(posedge clk);
        while (!in_ready);
        rgb_queue.push_back(convert_hsv(h, s, v));
        burst_left--;
    endtask

    task automatic wait_drained();
        while (rgb_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_hsv(16'd0, 12'd0, 12'd0);
        send_hsv(16'hFFFF, 12'hFFF, 12'hFFF);
        send_hsv(16'd0, 12'hFFF, 12'hFFF);
        send_hsv(HUE_W'(FULL_TURN - 1), 12'hFFF, 12'hFFF);
        send_hsv(16'd1234, 12'd1, 12'hFFF);
    endtask

    task automatic test_sectors();
        for (int k = 0; k < SECTORS; k++)
            send_hsv(HUE_W'(k * SECTOR + SECTOR / 2), 12'hFFF,
                     IN_COLOR_W'($urandom_range(1, 4095)));
        send_hsv(HUE_W'(SECTOR - 1), 12'hFFF, 12'hFFF);
        send_hsv(HUE_W'(5 * SECTOR - 1), 12'd3000, 12'd2000);
    endtask

    task automatic test_grey();
        send_hsv(16'd7000, 12'd0, 12'd2345);
        send_hsv(16'd2000, 12'd0, 12'hFFF);
    endtask

    task automatic test_hue_wrap();
        send_hsv(HUE_W'(FULL_TURN), 12'd1000, 12'd3000);
        send_hsv(HUE_W'(FULL_TURN + 1), 12'd1000, 12'd3000);
        send_hsv(16'hFFFF, 12'd2500, 12'd1500);
    endtask

    task automatic test_backpressure();
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_request = 1'b1;
        repeat (30)
            send_hsv(HUE_W'($urandom_range(0, 65535)), IN_COLOR_W'($urandom_range(0, 4095)),
                     IN_COLOR_W'($urandom_range(0, 4095)));
        while (hold_request)
            @(posedge clk);
        gaps_on = 1'b1;
    endtask

    function automatic logic [IN_COLOR_W-1:0] pick_colour();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return IN_COLOR_W'(CMAX);
            2:       return IN_COLOR_W'($urandom_range(1, 15));
            default: return IN_COLOR_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_random();
        logic [HUE_W-1:0] h;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0:       h = HUE_W'($urandom_range(0, 65535));
                1:       h = HUE_W'($urandom_range(FULL_TURN, 65535));
                2:       h = HUE_W'($urandom_range(0, SECTORS) * SECTOR
                                    + $urandom_range(0, 2) - 1);
                default: h = HUE_W'($urandom_range(0, FULL_TURN - 1));
            endcase
            send_hsv(h, pick_colour(), pick_colour());
        end
    endtask

    // output side: stall patterns that change now and then, plus the long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int cyc;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                cyc++;
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom_range(0, 1));
                    2:       out_ready = (cyc % 4 == 0);
                    default: out_ready = cyc[0];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        if (rst_n && out_valid && out_ready)
        begin
            if (rgb_queue.size() == 0)
            begin
                $error("unexpected result transaction: red %0d green %0d blue %0d",
                       red, green, blue);
                errors++;
            end
            else
            begin
                exp_rgb = rgb_queue.pop_front();
                if (red !== exp_rgb.red)
                begin
                    $error("red expected %0d actual %0d", exp_rgb.red, red);
                    errors++;
                end
                if (green !== exp_rgb.green)
                begin
                    $error("green expected %0d actual %0d", exp_rgb.green, green);
                    errors++;
                end
                if (blue !== exp_rgb.blue)
                begin
                    $error("blue expected %0d actual %0d", exp_rgb.blue, blue);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("hsv_to_rgb_converter_core verification failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        hue        = '0;
        saturation = '0;
        brightness = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_sectors();
        test_grey();
        test_hue_wrap();
        test_backpressure();
        test_random();

        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        repeat (12) @(posedge clk);
        if (errors == 0 && rgb_queue.size() == 0)
            $display("hsv_to_rgb_converter_core verification clean");
        else
            $display("hsv_to_rgb_converter_core verification failed");
        $finish;
    end

endmodule

[hsv_to_rgb_converter_core.f]
hw/rtl/h2r_pkg.sv
hw/rtl/hsv_to_rgb_converter_core.sv
tb/tb.sv
